// ===== rtl/core/dtbre_pkg.sv =====
// shared types, constants and helper functions of the two-bit run encoder
`timescale 1ns / 1ps

package dtbre_pkg;

  localparam int BASES_PER_WORD = 32;
  localparam int WORD_W         = 2 * BASES_PER_WORD;
  localparam int FILL_W         = $clog2(BASES_PER_WORD);
  localparam logic [FILL_W:0] FULL_FILL = (FILL_W + 1)'(BASES_PER_WORD);

  localparam int QUEUE_DEPTH = 4;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QIDX_W + 1;
  localparam int BATCH_N     = 3;

  localparam logic OP_LETTER = 1'b0;
  localparam logic OP_END    = 1'b1;
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  localparam logic [19:0] RUN_LIMIT_RESET = 20'hFFFFF;
  localparam logic [30:0] POS_MAX         = 31'h7FFFFFFF;
  localparam logic [31:0] CNT32_MAX       = 32'hFFFFFFFF;
  localparam logic [47:0] CNT48_MAX       = 48'hFFFFFFFFFFFF;

  typedef struct packed {
    logic        kind;
    logic        last;
    logic        is_acgt;
    logic [31:0] run_seq_id;
    logic [30:0] start_pos;
    logic [19:0] run_length;
    logic [47:0] packed_offset;
    logic [31:0] block_index;
    logic [63:0] data_word;
    logic [47:0] total_acgt_bases;
    logic [31:0] acgt_run_count;
    logic [31:0] gap_run_count;
  } res_t;

  typedef struct packed {
    logic [BATCH_N-1:0]       valid;
    res_t [BATCH_N-1:0]       ent;
  } batch_t;

  typedef struct packed {
    logic [31:0] bc;
    logic [31:0] ab;
    logic [31:0] gb;
    logic [47:0] abc;
  } cnt_t;

  typedef struct packed {
    logic       is_base;
    logic [1:0] code;
  } code_t;

  function automatic code_t base_code(input logic [7:0] c);
    code_t r;
    r.is_base = 1'b1;
    case (c)
      8'h41, 8'h61: r.code = 2'd0;
      8'h43, 8'h63: r.code = 2'd1;
      8'h47, 8'h67: r.code = 2'd2;
      8'h54, 8'h74: r.code = 2'd3;
      default: begin
        r.is_base = 1'b0;
        r.code    = 2'd0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] inc32(input logic [31:0] v);
    return (v == CNT32_MAX) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] add48(input logic [47:0] a, input logic [19:0] b);
    logic [48:0] s;
    s = {1'b0, a} + 49'(b);
    return s[48] ? CNT48_MAX : s[47:0];
  endfunction

  function automatic cnt_t count_run(input cnt_t c, input logic typ, input logic [19:0] len);
    cnt_t r;
    r    = c;
    r.bc = inc32(c.bc);
    if (typ) begin
      r.ab  = inc32(c.ab);
      r.abc = add48(c.abc, len);
    end else begin
      r.gb = inc32(c.gb);
    end
    return r;
  endfunction

  function automatic res_t make_run(input logic typ, input logic [31:0] seq,
                                    input logic [30:0] st, input logic [19:0] len,
                                    input logic [47:0] off, input logic [31:0] idx);
    res_t r;
    r               = '0;
    r.kind          = KIND_RUN;
    r.is_acgt       = typ;
    r.run_seq_id    = seq;
    r.start_pos     = st;
    r.run_length    = len;
    r.packed_offset = off;
    r.block_index   = idx;
    return r;
  endfunction

  function automatic res_t make_word(input logic [63:0] w);
    res_t r;
    r           = '0;
    r.kind      = KIND_WORD;
    r.data_word = w;
    return r;
  endfunction

endpackage

// ===== rtl/core/dna_two_bit_run_encoder_core.sv =====
// top level of the dna two-bit run encoder: ports, run limit register, result queue
// latency: with the result queue empty, the first result of a transaction is on the output the cycle after it is accepted
// throughput: one input transaction per cycle while each gives at most one result and the
//   output is not stalled; a transaction giving n results (up to three) holds the single output
//   port until all n are taken, and input ready drops while more than one result waits in the result queue
// reset: synchronous, clears all run, packing and counter state; run limit returns to 1048575
`timescale 1ns / 1ps

module dna_two_bit_run_encoder_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // letter[7:0], seq_id[39:8]
  input  logic         s_axis_tuser,   // op
  input  logic         s_axis_tlast,   // seq_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [343:0] m_axis_tdata,   // is_acgt[0], run_seq_id[32:1], start_pos[63:33],
                                       // run_length[83:64], packed_offset[131:84],
                                       // block_index[163:132], data_word[227:164],
                                       // total_acgt_bases[275:228], acgt_run_count[307:276],
                                       // gap_run_count[339:308], zero[343:340]
  output logic         m_axis_tuser,   // kind
  output logic         m_axis_tlast,   // last
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [19:0]  cfg_data        // max_run_length
);

  logic [19:0]       max_run_length;
  logic [19:0]       limit;
  logic              take;
  logic              room;
  dtbre_pkg::batch_t batch;
  dtbre_pkg::res_t   head;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_run_length <= dtbre_pkg::RUN_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_run_length <= cfg_data;
    end
  end

  assign cfg_ready     = 1'b1;
  // zero limit acts as one
  assign limit         = (max_run_length == '0) ? 20'd1 : max_run_length;
  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && room;

  dtbre_encoder u_encoder (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .op      (s_axis_tuser),
    .letter  (s_axis_tdata[7:0]),
    .seq_id  (s_axis_tdata[39:8]),
    .seq_end (s_axis_tlast),
    .limit   (limit),
    .batch   (batch)
  );

  dtbre_res_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .batch      (batch),
    .pop        (m_axis_tready),
    .head       (head),
    .head_valid (m_axis_tvalid),
    .room       (room)
  );

  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;
  assign m_axis_tdata = {4'b0000, head.gap_run_count, head.acgt_run_count,
                         head.total_acgt_bases, head.data_word, head.block_index,
                         head.packed_offset, head.run_length, head.start_pos,
                         head.run_seq_id, head.is_acgt};

endmodule

// ===== rtl/core/dtbre_encoder.sv =====
// run tracking, base packing and record generation for one transaction per cycle
`timescale 1ns / 1ps

module dtbre_encoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic                 op,
  input  logic [7:0]           letter,
  input  logic [31:0]          seq_id,
  input  logic                 seq_end,
  input  logic [19:0]          limit,
  output dtbre_pkg::batch_t    batch
);

  logic                              in_sequence, in_sequence_next;
  logic [30:0]                       position, position_next;
  logic                              cur_is_acgt, cur_is_acgt_next;
  logic [31:0]                       cur_seq, cur_seq_next;
  logic [30:0]                       cur_start, cur_start_next;
  logic [19:0]                       cur_run_length, cur_run_length_next;
  logic [47:0]                       cur_offset, cur_offset_next;
  logic [47:0]                       bases_written, bases_written_next;
  logic [dtbre_pkg::WORD_W-1:0]      pack_word, pack_word_next;
  logic [dtbre_pkg::FILL_W-1:0]      pack_fill, pack_fill_next;
  dtbre_pkg::cnt_t                   cnt, cnt_next;

  always_comb begin
    dtbre_pkg::code_t              ci;
    logic                          fresh;
    logic [30:0]                   p0;
    logic [31:0]                   s0;
    logic                          t0, t1;
    logic [30:0]                   a0, a1;
    logic [19:0]                   l0, l1, l2;
    logic [47:0]                   o0, o1;
    logic                          split, change;
    logic [dtbre_pkg::FILL_W:0]    fill_inc;
    logic [dtbre_pkg::FILL_W:0]    rem;
    logic [dtbre_pkg::FILL_W+1:0]  shamt;
    dtbre_pkg::cnt_t               c;
    dtbre_pkg::batch_t             b;

    in_sequence_next    = in_sequence;
    position_next       = position;
    cur_is_acgt_next    = cur_is_acgt;
    cur_seq_next        = cur_seq;
    cur_start_next      = cur_start;
    cur_run_length_next = cur_run_length;
    cur_offset_next     = cur_offset;
    bases_written_next  = bases_written;
    pack_word_next      = pack_word;
    pack_fill_next      = pack_fill;
    c                   = cnt;
    b                   = '0;

    ci       = dtbre_pkg::base_code(letter);
    fresh    = !in_sequence;
    p0       = fresh ? '0 : position;
    s0       = fresh ? seq_id : cur_seq;
    t0       = fresh ? 1'b0 : cur_is_acgt;
    a0       = fresh ? '0 : cur_start;
    l0       = fresh ? '0 : cur_run_length;
    o0       = fresh ? bases_written : cur_offset;
    split    = l0 >= limit;
    change   = ci.is_base != t0;
    t1       = t0;
    a1       = a0;
    l1       = l0;
    o1       = o0;
    l2       = '0;
    fill_inc = {1'b0, pack_fill} + 1'b1;
    rem      = dtbre_pkg::FULL_FILL - {1'b0, pack_fill};
    shamt    = {rem, 1'b0};

    if (take) begin
      if (op == dtbre_pkg::OP_LETTER) begin
        // split or type change closes the pending run
        if (split || (change && l0 != '0)) begin
          b.ent[0]   = dtbre_pkg::make_run(t0, s0, a0, l0, o0, c.bc);
          b.valid[0] = 1'b1;
          c          = dtbre_pkg::count_run(c, t0, l0);
        end
        if (split || change) begin
          t1 = change ? ci.is_base : t0;
          a1 = p0;
          l1 = '0;
          o1 = bases_written;
        end
        l2 = l1 + 20'd1;
        if (ci.is_base) begin
          bases_written_next = dtbre_pkg::add48(bases_written, 20'd1);
          if (fill_inc == dtbre_pkg::FULL_FILL) begin
            b.ent[1]       = dtbre_pkg::make_word(64'({pack_word[dtbre_pkg::WORD_W-3:0],
                                                      ci.code}));
            b.valid[1]     = 1'b1;
            pack_word_next = '0;
            pack_fill_next = '0;
          end else begin
            pack_word_next = {pack_word[dtbre_pkg::WORD_W-3:0], ci.code};
            pack_fill_next = fill_inc[dtbre_pkg::FILL_W-1:0];
          end
        end
        position_next       = (p0 == dtbre_pkg::POS_MAX) ? p0 : p0 + 31'd1;
        cur_is_acgt_next    = t1;
        cur_seq_next        = s0;
        cur_start_next      = a1;
        cur_run_length_next = l2;
        cur_offset_next     = o1;
        in_sequence_next    = 1'b1;
        if (seq_end) begin
          b.ent[2]         = dtbre_pkg::make_run(t1, s0, a1, l2, o1, c.bc);
          b.valid[2]       = 1'b1;
          c                = dtbre_pkg::count_run(c, t1, l2);
          in_sequence_next = 1'b0;
        end
      end else begin
        // end of store: pending run, partial word, sentinel
        if (in_sequence && cur_run_length != '0) begin
          b.ent[0]   = dtbre_pkg::make_run(cur_is_acgt, cur_seq, cur_start,
                                           cur_run_length, cur_offset, c.bc);
          b.valid[0] = 1'b1;
          c          = dtbre_pkg::count_run(c, cur_is_acgt, cur_run_length);
        end
        if (pack_fill != '0) begin
          b.ent[1]   = dtbre_pkg::make_word(64'(pack_word << shamt));
          b.valid[1] = 1'b1;
        end
        b.ent[2]                  = dtbre_pkg::make_run(1'b0, dtbre_pkg::CNT32_MAX,
                                                        dtbre_pkg::POS_MAX, '0,
                                                        bases_written, c.bc);
        b.ent[2].total_acgt_bases = c.abc;
        b.ent[2].acgt_run_count   = c.ab;
        b.ent[2].gap_run_count    = c.gb;
        b.valid[2]                = 1'b1;
        in_sequence_next          = 1'b0;
        position_next             = '0;
        cur_is_acgt_next          = 1'b0;
        cur_seq_next              = '0;
        cur_start_next            = '0;
        cur_run_length_next       = '0;
        cur_offset_next           = '0;
        bases_written_next        = '0;
        pack_word_next            = '0;
        pack_fill_next            = '0;
        c                         = '0;
      end
    end

    // last flag on the final result of the transaction
    if (b.valid[2]) begin
      b.ent[2].last = 1'b1;
    end else if (b.valid[1]) begin
      b.ent[1].last = 1'b1;
    end else if (b.valid[0]) begin
      b.ent[0].last = 1'b1;
    end

    cnt_next = c;
    batch    = b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sequence    <= 1'b0;
      position       <= '0;
      cur_is_acgt    <= 1'b0;
      cur_seq        <= '0;
      cur_start      <= '0;
      cur_run_length <= '0;
      cur_offset     <= '0;
      bases_written  <= '0;
      pack_word      <= '0;
      pack_fill      <= '0;
      cnt            <= '0;
    end else begin
      in_sequence    <= in_sequence_next;
      position       <= position_next;
      cur_is_acgt    <= cur_is_acgt_next;
      cur_seq        <= cur_seq_next;
      cur_start      <= cur_start_next;
      cur_run_length <= cur_run_length_next;
      cur_offset     <= cur_offset_next;
      bases_written  <= bases_written_next;
      pack_word      <= pack_word_next;
      pack_fill      <= pack_fill_next;
      cnt            <= cnt_next;
    end
  end

endmodule

// ===== rtl/core/dtbre_res_queue.sv =====
// small result queue taking up to three results per cycle and giving one
`timescale 1ns / 1ps

module dtbre_res_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dtbre_pkg::batch_t    batch,
  input  logic                 pop,
  output dtbre_pkg::res_t      head,
  output logic                 head_valid,
  output logic                 room
);

  dtbre_pkg::res_t                q [dtbre_pkg::QUEUE_DEPTH];
  dtbre_pkg::res_t                q_next [dtbre_pkg::QUEUE_DEPTH];
  logic [dtbre_pkg::QCNT_W-1:0]   count, count_next;

  always_comb begin
    logic [dtbre_pkg::QCNT_W-1:0] idx;
    q_next = q;
    idx    = count;
    if (pop && count != '0) begin
      for (int i = 0; i < dtbre_pkg::QUEUE_DEPTH - 1; i++) begin
        q_next[i] = q[i+1];
      end
      idx = count - 1'b1;
    end
    if (push) begin
      for (int k = 0; k < dtbre_pkg::BATCH_N; k++) begin
        if (batch.valid[k]) begin
          q_next[idx[dtbre_pkg::QIDX_W-1:0]] = batch.ent[k];
          idx = idx + 1'b1;
        end
      end
    end
    count_next = idx;
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign head       = q[0];
  assign head_valid = count != '0;
  assign room       = count <= dtbre_pkg::QCNT_W'(1);

endmodule

// ===== bench/tb_dna_two_bit_run_encoder_core.sv =====
// self-checking bench for the dna two-bit run encoder core: directed table, then random letter streams
`timescale 1ns / 1ps

module tb_dna_two_bit_run_encoder_core;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 250;
  localparam int N_ROWS        = 25;
  localparam int N_PHASES      = 6;

  typedef struct {
    bit              cfg_wr;
    logic [19:0]     cfg_val;
    logic            op;
    logic [7:0]      letter;
    logic [31:0]     seq;
    logic            seq_end;
    bit              typed;
    dtbre_pkg::res_t want;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic         s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [343:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [19:0]  cfg_data;

  dna_two_bit_run_encoder_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // encoder mirror
  logic [19:0] run_limit;
  bit          in_seq;
  logic [30:0] seq_pos;
  bit          run_is_base;
  logic [31:0] run_seq;
  logic [30:0] run_start;
  logic [19:0] run_len;
  logic [47:0] run_offset;
  logic [47:0] bases_packed;
  logic [63:0] word_acc;
  int unsigned word_fill;
  logic [31:0] record_count;
  logic [31:0] base_run_count;
  logic [31:0] gap_count;
  logic [47:0] base_total;

  dtbre_pkg::res_t step_out[$];
  dtbre_pkg::res_t records_due[$];

  dir_row_t dir_rows[N_ROWS];
  logic [7:0] base_letters[8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};
  logic [7:0] gap_letters[8]  = '{"N", "n", "R", "Y", "x", "-", "*", 8'h00};

  bit          fast_tx;
  bit          fast_rx;
  bit          hold_req;
  int unsigned items_sent;
  int unsigned cfg_writes;
  int unsigned mismatches;
  int unsigned runs_seen;
  int unsigned words_seen;
  int unsigned sentinels_seen;
  int unsigned cycle_count = 0;

  function automatic logic [31:0] bump32(input logic [31:0] v);
    return (v == dtbre_pkg::CNT32_MAX) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] sum48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? dtbre_pkg::CNT48_MAX : s[47:0];
  endfunction

  // {is base, two-bit code}
  function automatic logic [2:0] letter_code(input logic [7:0] c);
    case (c)
      "A", "a": return 3'b100;
      "C", "c": return 3'b101;
      "G", "g": return 3'b110;
      "T", "t": return 3'b111;
      default: return 3'b000;
    endcase
  endfunction

  function automatic void clear_encoder();
    in_seq         = 1'b0;
    seq_pos        = '0;
    run_is_base    = 1'b0;
    run_seq        = '0;
    run_start      = '0;
    run_len        = '0;
    run_offset     = '0;
    bases_packed   = '0;
    word_acc       = '0;
    word_fill      = 0;
    record_count   = '0;
    base_run_count = '0;
    gap_count      = '0;
    base_total     = '0;
  endfunction

  function automatic void open_run(input bit is_base);
    run_is_base = is_base;
    run_start   = seq_pos;
    run_len     = '0;
    run_offset  = bases_packed;
  endfunction

  function automatic void close_run();
    dtbre_pkg::res_t r;
    if (run_len != 0) begin
      r               = '0;
      r.kind          = dtbre_pkg::KIND_RUN;
      r.is_acgt       = run_is_base;
      r.run_seq_id    = run_seq;
      r.start_pos     = run_start;
      r.run_length    = run_len;
      r.packed_offset = run_offset;
      r.block_index   = record_count;
      step_out.push_back(r);
      record_count = bump32(record_count);
      if (run_is_base) begin
        base_run_count = bump32(base_run_count);
        base_total     = sum48(base_total, 48'(run_len));
      end else begin
        gap_count = bump32(gap_count);
      end
    end
  endfunction

  function automatic void push_word(input logic [63:0] w);
    dtbre_pkg::res_t r;
    r           = '0;
    r.kind      = dtbre_pkg::KIND_WORD;
    r.data_word = w;
    step_out.push_back(r);
  endfunction

  function automatic void encode_item(input logic op, input logic [7:0] letter,
                                      input logic [31:0] seq, input logic seq_end);
    logic [19:0]     lim;
    logic [2:0]      lc;
    dtbre_pkg::res_t r;
    step_out.delete();
    lim = (run_limit == 0) ? 20'd1 : run_limit;
    if (op == dtbre_pkg::OP_LETTER) begin
      lc = letter_code(letter);
      if (!in_seq) begin
        in_seq  = 1'b1;
        seq_pos = '0;
        run_seq = seq;
        open_run(1'b0);
      end
      if (run_len >= lim) begin
        close_run();
        open_run(run_is_base);
      end
      if (lc[2] != run_is_base) begin
        close_run();
        open_run(lc[2]);
      end
      run_len++;
      if (lc[2]) begin
        word_acc     = {word_acc[61:0], lc[1:0]};
        word_fill++;
        bases_packed = sum48(bases_packed, 48'd1);
        if (word_fill == dtbre_pkg::BASES_PER_WORD) begin
          push_word(word_acc);
          word_acc  = '0;
          word_fill = 0;
        end
      end
      if (seq_pos != dtbre_pkg::POS_MAX) seq_pos++;
      if (seq_end) begin
        close_run();
        in_seq = 1'b0;
      end
    end else begin
      if (in_seq) close_run();
      // partial word: bases move to the top, low bits stay zero
      if (word_fill != 0)
        push_word(word_acc << (2 * (dtbre_pkg::BASES_PER_WORD - word_fill)));
      r                  = '0;
      r.kind             = dtbre_pkg::KIND_RUN;
      r.run_seq_id       = dtbre_pkg::CNT32_MAX;
      r.start_pos        = dtbre_pkg::POS_MAX;
      r.packed_offset    = bases_packed;
      r.block_index      = record_count;
      r.total_acgt_bases = base_total;
      r.acgt_run_count   = base_run_count;
      r.gap_run_count    = gap_count;
      step_out.push_back(r);
      clear_encoder();
    end
    if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch %0s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    dtbre_pkg::res_t got;
    dtbre_pkg::res_t want;
    got                  = '0;
    got.kind             = m_axis_tuser;
    got.last             = m_axis_tlast;
    got.is_acgt          = m_axis_tdata[0];
    got.run_seq_id       = m_axis_tdata[32:1];
    got.start_pos        = m_axis_tdata[63:33];
    got.run_length       = m_axis_tdata[83:64];
    got.packed_offset    = m_axis_tdata[131:84];
    got.block_index      = m_axis_tdata[163:132];
    got.data_word        = m_axis_tdata[227:164];
    got.total_acgt_bases = m_axis_tdata[275:228];
    got.acgt_run_count   = m_axis_tdata[307:276];
    got.gap_run_count    = m_axis_tdata[339:308];
    if (records_due.size() == 0) begin
      note_mismatch("result with nothing expected", got.data_word, '0);
      return;
    end
    want = records_due.pop_front();
    if (got.kind !== want.kind) note_mismatch("kind", 64'(got.kind), 64'(want.kind));
    if (got.last !== want.last) note_mismatch("last", 64'(got.last), 64'(want.last));
    if (got.is_acgt !== want.is_acgt)
      note_mismatch("is_acgt", 64'(got.is_acgt), 64'(want.is_acgt));
    if (got.run_seq_id !== want.run_seq_id)
      note_mismatch("run_seq_id", 64'(got.run_seq_id), 64'(want.run_seq_id));
    if (got.start_pos !== want.start_pos)
      note_mismatch("start_pos", 64'(got.start_pos), 64'(want.start_pos));
    if (got.run_length !== want.run_length)
      note_mismatch("run_length", 64'(got.run_length), 64'(want.run_length));
    if (got.packed_offset !== want.packed_offset)
      note_mismatch("packed_offset", 64'(got.packed_offset), 64'(want.packed_offset));
    if (got.block_index !== want.block_index)
      note_mismatch("block_index", 64'(got.block_index), 64'(want.block_index));
    if (got.data_word !== want.data_word)
      note_mismatch("data_word", got.data_word, want.data_word);
    if (got.total_acgt_bases !== want.total_acgt_bases)
      note_mismatch("total_acgt_bases", 64'(got.total_acgt_bases),
                    64'(want.total_acgt_bases));
    if (got.acgt_run_count !== want.acgt_run_count)
      note_mismatch("acgt_run_count", 64'(got.acgt_run_count), 64'(want.acgt_run_count));
    if (got.gap_run_count !== want.gap_run_count)
      note_mismatch("gap_run_count", 64'(got.gap_run_count), 64'(want.gap_run_count));
    if (want.kind == dtbre_pkg::KIND_WORD) words_seen++;
    else if (want.run_seq_id == dtbre_pkg::CNT32_MAX && want.start_pos == dtbre_pkg::POS_MAX)
      sentinels_seen++;
    else runs_seen++;
  endtask

  task automatic send_item(input logic op, input logic [7:0] letter, input logic [31:0] seq,
                           input logic seq_end, input bit typed,
                           input dtbre_pkg::res_t want);
    int gap;
    gap = fast_tx ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {seq, letter};
    s_axis_tuser  <= op;
    s_axis_tlast  <= seq_end;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    encode_item(op, letter, seq, seq_end);
    if (typed) records_due.push_back(want);
    else foreach (step_out[i]) records_due.push_back(step_out[i]);
    items_sent++;
  endtask

  task automatic send_letter(input logic [7:0] letter, input logic [31:0] seq,
                             input logic seq_end);
    send_item(dtbre_pkg::OP_LETTER, letter, seq, seq_end, 1'b0, '0);
  endtask

  task automatic send_end();
    send_item(dtbre_pkg::OP_END, 8'($urandom), $urandom, 1'($urandom), 1'b0, '0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (records_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [19:0] v);
    wait_drained();
    // letters that give no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    run_limit = v;
    cfg_writes++;
  endtask

  task automatic random_action();
    int          pick;
    int          len;
    bit          gap_run;
    logic [31:0] id;
    pick = $urandom_range(0, 99);
    id   = $urandom;
    if ($urandom_range(0, 19) == 0) fast_tx = !fast_tx;
    if (pick < 75) begin
      len     = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 20);
      gap_run = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 5) == 0) gap_run = !gap_run;
        send_letter(gap_run ? gap_letters[$urandom_range(0, 7)] : base_letters[$urandom_range(0, 7)],
                    (k == 0) ? id : $urandom, k == len - 1);
      end
    end else if (pick < 88) begin
      send_letter(8'($urandom), id, 1'($urandom));
    end else if (pick < 94) begin
      // sequence left open, continued by whatever follows
      repeat ($urandom_range(1, 6)) send_letter(base_letters[$urandom_range(0, 7)], id, 1'b0);
    end else begin
      send_end();
    end
  endtask

  function automatic dir_row_t mk_row(input bit w, input logic [19:0] v, input logic op,
                                      input logic [7:0] l, input logic [31:0] s,
                                      input logic e);
    dir_row_t r;
    r.cfg_wr  = w;
    r.cfg_val = v;
    r.op      = op;
    r.letter  = l;
    r.seq     = s;
    r.seq_end = e;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic void load_table();
    dir_rows[0]  = mk_row(1'b0, 20'd0, dtbre_pkg::OP_END, 8'h00, 32'h0, 1'b0);
    dir_rows[1]  = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "A", 32'hFFFFFFFF, 1'b1);
    dir_rows[2]  = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "a", 32'h00000000, 1'b0);
    dir_rows[3]  = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "C", 32'h00000005, 1'b0);
    dir_rows[4]  = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "c", 32'hFFFFFFFF, 1'b0);
    dir_rows[5]  = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "G", 32'h0, 1'b0);
    dir_rows[6]  = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "g", 32'h0, 1'b0);
    dir_rows[7]  = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "T", 32'h0, 1'b0);
    dir_rows[8]  = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "t", 32'h0, 1'b0);
    dir_rows[9]  = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "N", 32'h0, 1'b0);
    dir_rows[10] = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "n", 32'h0, 1'b0);
    dir_rows[11] = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, 8'h00, 32'h0, 1'b0);
    dir_rows[12] = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, 8'hFF, 32'h0, 1'b1);
    dir_rows[13] = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "G", 32'h7, 1'b0);
    dir_rows[14] = mk_row(1'b0, 20'd0, dtbre_pkg::OP_END, 8'hFF, 32'hFFFFFFFF, 1'b1);
    dir_rows[15] = mk_row(1'b1, 20'd0, dtbre_pkg::OP_LETTER, "A", 32'h1, 1'b0);
    dir_rows[16] = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "A", 32'h1, 1'b0);
    dir_rows[17] = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "N", 32'h1, 1'b1);
    dir_rows[18] = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "T", 32'h3, 1'b0);
    dir_rows[19] = mk_row(1'b0, 20'd0, dtbre_pkg::OP_END, 8'h00, 32'h0, 1'b0);
    dir_rows[20] = mk_row(1'b1, 20'd2, dtbre_pkg::OP_LETTER, "x", 32'h2, 1'b0);
    dir_rows[21] = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "x", 32'h2, 1'b0);
    dir_rows[22] = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "x", 32'h2, 1'b0);
    dir_rows[23] = mk_row(1'b0, 20'd0, dtbre_pkg::OP_LETTER, "A", 32'h2, 1'b1);
    dir_rows[24] = mk_row(1'b0, 20'd0, dtbre_pkg::OP_END, 8'h00, 32'h0, 1'b0);
    // end of store straight after reset: sentinel only
    dir_rows[0].typed                = 1'b1;
    dir_rows[0].want.kind            = dtbre_pkg::KIND_RUN;
    dir_rows[0].want.last            = 1'b1;
    dir_rows[0].want.run_seq_id      = 32'hFFFFFFFF;
    dir_rows[0].want.start_pos       = 31'h7FFFFFFF;
    // one base with the widest id, ended at once
    dir_rows[1].typed                = 1'b1;
    dir_rows[1].want.kind            = dtbre_pkg::KIND_RUN;
    dir_rows[1].want.last            = 1'b1;
    dir_rows[1].want.is_acgt         = 1'b1;
    dir_rows[1].want.run_seq_id      = 32'hFFFFFFFF;
    dir_rows[1].want.run_length      = 20'd1;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               records_due.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : result_sink
    int gap;
    m_axis_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = fast_rx ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      check_result();
      if ($urandom_range(0, 29) == 0) fast_rx = !fast_rx;
    end
  end

  initial begin : letter_source
    logic [19:0] lim;
    int unsigned phase_stop;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= dtbre_pkg::OP_LETTER;
    s_axis_tlast  <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    run_limit = dtbre_pkg::RUN_LIMIT_RESET;
    clear_encoder();
    load_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_wr) write_limit(dir_rows[i].cfg_val);
      send_item(dir_rows[i].op, dir_rows[i].letter, dir_rows[i].seq, dir_rows[i].seq_end,
                dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: lim = 20'd1;
        1: lim = 20'($urandom_range(2, 40));
        2: lim = 20'd3;
        3: lim = dtbre_pkg::RUN_LIMIT_RESET;
        4: lim = 20'($urandom_range(2, 1048575));
        default: lim = 20'($urandom_range(4, 12));
      endcase
      write_limit(lim);
      fast_tx = ($urandom_range(0, 2) == 0);
      if (ph == 2) begin
        // long receiver hold while letters keep coming, then wait for the backlog
        hold_req = 1'b1;
        fast_tx  = 1'b1;
        repeat (24) send_letter(base_letters[$urandom_range(0, 7)], $urandom, 1'b1);
        wait_drained();
        fast_tx = 1'b0;
      end
      phase_stop = N_ROWS + (ph + 1) * RANDOM_ITEMS / N_PHASES;
      while (items_sent < phase_stop) random_action();
      send_end();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d letter and end-of-store transactions over %0d run limit settings",
             items_sent, cfg_writes);
    $display("checked %0d run records, %0d packed words, %0d end-of-store records",
             runs_seen, words_seen, sentinels_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
